// ===== hdl/hcbp_pkg.sv =====
`timescale 1ns / 1ps

package hcbp_pkg;

    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int SYM_W     = 8;
    localparam int BYTE_BITS = 8;
    localparam int PEND_W    = 7;
    localparam int WIN_W     = PEND_W + CODE_W;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } table_rd_t;

    typedef struct packed {
        logic valid;
        logic flush;
    } issue_t;

endpackage

// ===== hdl/hcbp_table.sv =====
`timescale 1ns / 1ps

module hcbp_table #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic                       rd_en,
    input  logic [hcbp_pkg::SYM_W-1:0] symbol,
    input  logic [hcbp_pkg::CODE_W-1:0] code_word,
    input  logic [hcbp_pkg::LEN_W-1:0] code_length,
    output hcbp_pkg::table_rd_t        rd
);
    import hcbp_pkg::*;

    localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int CAP_I  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_I);
    localparam logic [SYM_W:0]   SYM_LIM = (SYM_W + 1)'(SYMBOL_COUNT);

    logic [CODE_W+LEN_W-1:0] mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] loaded_reg;
    logic [CODE_W+LEN_W-1:0] q_reg;
    logic                    hit_reg;

    logic [ADDR_W-1:0] addr;
    logic              in_range;
    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  left_sh;
    logic [CODE_W-1:0] code_left;

    assign addr      = symbol[ADDR_W-1:0];
    assign in_range  = ({1'b0, symbol} < SYM_LIM);
    assign len_sat   = (code_length > LEN_CAP) ? LEN_CAP : code_length;
    assign left_sh   = LEN_W'(CODE_W) - len_sat;
    assign code_left = code_word << left_sh;

    // store codes left-aligned; the shift drops bits above the length
    always_ff @(posedge clk)
    begin
        if (wr_en && in_range)
        begin
            mem[addr] <= {code_left, len_sat};
        end
        if (rd_en)
        begin
            q_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en && in_range)
            begin
                loaded_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= in_range && (loaded_reg[addr] || (wr_en && in_range));
            end
        end
    end

    assign rd.code = hit_reg ? q_reg[CODE_W+LEN_W-1:LEN_W] : '0;
    assign rd.len  = hit_reg ? q_reg[LEN_W-1:0] : '0;

endmodule

// ===== hdl/hcbp_packer.sv =====
`timescale 1ns / 1ps

module hcbp_packer (
    input  logic                clk,
    input  logic                rst_n,
    input  hcbp_pkg::issue_t    issue,
    input  hcbp_pkg::table_rd_t rd,
    output logic                item_ready,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [7:0]          out_byte,
    output logic [3:0]          valid_bits,
    output logic                stream_end,
    output logic                last
);
    import hcbp_pkg::*;

    logic              s1_valid_reg;
    logic              s1_flush_reg;
    logic [1:0]        k_reg;
    logic [1:0]        k_next;
    logic [PEND_W-1:0] pend_la_reg;
    logic [PEND_W-1:0] pend_la_next;
    logic [2:0]        pend_cnt_reg;
    logic [2:0]        pend_cnt_next;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic [3:0]        valid_bits_reg;
    logic              stream_end_reg;
    logic              last_reg;

    logic [LEN_W-1:0]  total;
    logic [2:0]        n_bytes;
    logic [WIN_W-1:0]  window;
    logic [7:0]        enc_byte;
    logic [PEND_W-1:0] enc_pend;
    logic [7:0]        flush_byte;
    logic              out_free;
    logic              enc_last;
    logic              emit;
    logic              done;

    assign total    = LEN_W'(pend_cnt_reg) + rd.len;
    assign n_bytes  = total[5:3];
    assign window   = {pend_la_reg, {CODE_W{1'b0}}}
                    | ({rd.code, {PEND_W{1'b0}}} >> pend_cnt_reg);
    assign out_free = !out_valid_reg || result_ready;
    assign enc_last = ({1'b0, k_reg} == (n_bytes - 3'd1));
    assign flush_byte = 8'({1'b0, pend_la_reg} >> (3'd7 - pend_cnt_reg));

    always_comb
    begin
        unique case (k_reg)
            2'd0: enc_byte = window[38:31];
            2'd1: enc_byte = window[30:23];
            2'd2: enc_byte = window[22:15];
            2'd3: enc_byte = window[14:7];
        endcase
    end

    always_comb
    begin
        unique case (n_bytes)
            3'd0:    enc_pend = window[38:32];
            3'd1:    enc_pend = window[30:24];
            3'd2:    enc_pend = window[22:16];
            3'd3:    enc_pend = window[14:8];
            3'd4:    enc_pend = window[6:0];
            default: enc_pend = '0;
        endcase
    end

    always_comb
    begin
        emit = 1'b0;
        done = 1'b0;
        if (s1_valid_reg)
        begin
            if (s1_flush_reg)
            begin
                emit = out_free;
                done = out_free;
            end
            else if (n_bytes == 3'd0)
            begin
                done = 1'b1;
            end
            else
            begin
                emit = out_free;
                done = out_free && enc_last;
            end
        end
    end

    assign item_ready = !s1_valid_reg || done;

    always_comb
    begin
        k_next        = k_reg;
        pend_la_next  = pend_la_reg;
        pend_cnt_next = pend_cnt_reg;
        if (issue.valid)
        begin
            k_next = 2'd0;
        end
        else if (emit && !done)
        begin
            k_next = k_reg + 2'd1;
        end
        if (done && s1_flush_reg)
        begin
            pend_la_next  = '0;
            pend_cnt_next = '0;
        end
        else if (done)
        begin
            pend_la_next  = enc_pend;
            pend_cnt_next = total[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_flush_reg  <= 1'b0;
            k_reg         <= '0;
            pend_la_reg   <= '0;
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue.valid)
            begin
                s1_valid_reg <= 1'b1;
                s1_flush_reg <= issue.flush;
            end
            else if (done)
            begin
                s1_valid_reg <= 1'b0;
            end
            k_reg        <= k_next;
            pend_la_reg  <= pend_la_next;
            pend_cnt_reg <= pend_cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg   <= s1_flush_reg ? flush_byte : enc_byte;
            valid_bits_reg <= s1_flush_reg ? {1'b0, pend_cnt_reg} : 4'(BYTE_BITS);
            stream_end_reg <= s1_flush_reg;
            last_reg       <= s1_flush_reg || enc_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign valid_bits   = valid_bits_reg;
    assign stream_end   = stream_end_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_la_reg & (7'h7F >> pend_cnt_reg)) == 7'd0)
        else $error("packer holds stray bits below the pending count");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stream_end_reg) |-> last_reg)
        else $error("stream end word not marked last");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done && s1_flush_reg) |=> (pend_cnt_reg == 3'd0 && pend_la_reg == 7'd0))
        else $error("flush left bits in the packer");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_flush_reg) |-> ({1'b0, k_reg} <= n_bytes))
        else $error("byte index past the bytes of the symbol");
`endif

endmodule

// ===== hdl/huffman_code_bit_packer_core.sv =====
// A result word is registered in the output register after its encode or flush word passes the
// packer stage. Throughput: one word per cycle while the output is free; an encode that fills k bytes
// holds the input off until its last byte is out, set by the single output register carrying
// one byte per cycle. Loads use the code table write port and give no result. Reset (rst_n,
// async, low) empties the packer and marks every table entry unloaded.
`timescale 1ns / 1ps

module huffman_code_bit_packer_core #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [1:0]                  command,
    input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
    input  logic [hcbp_pkg::CODE_W-1:0] code_word,
    input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [7:0]                  out_byte,
    output logic [3:0]                  valid_bits,
    output logic                        stream_end,
    output logic                        last
);
    import hcbp_pkg::*;

    logic      accept;
    issue_t    issue;
    table_rd_t rd;

    assign accept      = item_valid && item_ready;
    assign issue.valid = accept && (command == CMD_ENCODE || command == CMD_FLUSH);
    assign issue.flush = (command == CMD_FLUSH);

    hcbp_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (accept && command == CMD_LOAD),
        .rd_en       (accept && command == CMD_ENCODE),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .rd          (rd)
    );

    hcbp_packer u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (issue),
        .rd           (rd),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .valid_bits   (valid_bits),
        .stream_end   (stream_end),
        .last         (last)
    );

endmodule

// ===== bench/huffman_code_bit_packer_checker.sv =====
`timescale 1ns / 1ps

module huffman_code_bit_packer_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic                        item_ready,
    input  logic [1:0]                  command,
    input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
    input  logic [hcbp_pkg::CODE_W-1:0] code_word,
    input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  logic [7:0]                  out_byte,
    input  logic [3:0]                  valid_bits,
    input  logic                        stream_end,
    input  logic                        last,
    output int                          fail_count,
    output int                          words_due
);
    import hcbp_pkg::*;

    localparam int LEN_CAP   = 32;
    localparam int MAX_BYTES = 4;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] bits;
        logic       stream_end;
        logic       last;
    } out_word_t;

    logic [CODE_W-1:0] code_table [256];
    logic [LEN_W-1:0]  length_table [256];
    logic [PEND_W-1:0] spill_bits;
    logic [2:0]        spill_count;
    out_word_t         due_words [$];

    initial
    begin
        fail_count = 0;
        words_due  = 0;
    end

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    task automatic pack_symbol(input logic [SYM_W-1:0] sym);
        int          len;
        int          total;
        int          n;
        logic [31:0] code;
        logic [63:0] window;
        logic [63:0] shifted;
        out_word_t   w;
        len = length_table[sym];
        if (len > LEN_CAP)
            len = LEN_CAP;
        code   = code_table[sym] & 32'((64'd1 << len) - 64'd1);
        window = (64'(spill_bits) << len) | 64'(code);
        total  = spill_count + len;
        n      = 0;
        while (total >= BYTE_BITS && n < MAX_BYTES)
        begin
            shifted      = window >> (total - BYTE_BITS);
            w.data       = shifted[7:0];
            w.bits       = 4'(BYTE_BITS);
            w.stream_end = 1'b0;
            w.last       = (total - BYTE_BITS < BYTE_BITS) || (n == MAX_BYTES - 1);
            due_words    = {due_words, w};
            n++;
            total -= BYTE_BITS;
        end
        spill_bits  = 7'(window & ((64'd1 << total) - 64'd1));
        spill_count = 3'(total);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t got;
        out_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 256; i++)
            begin
                code_table[i]   = '0;
                length_table[i] = '0;
            end
            spill_bits  = '0;
            spill_count = '0;
            due_words.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                got = '{out_byte, valid_bits, stream_end, last};
                if (due_words.size() == 0)
                begin
                    $display("%0t: unexpected word expected none actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = due_words.pop_front();
                    check_field("out_byte", want.data, got.data);
                    check_field("valid_bits", want.bits, got.bits);
                    check_field("stream_end", want.stream_end, got.stream_end);
                    check_field("last", want.last, got.last);
                end
            end
            if (item_valid && item_ready)
            begin
                case (command)
                    CMD_LOAD:
                    begin
                        code_table[symbol]   = code_word;
                        length_table[symbol] = (code_length > LEN_CAP) ? 6'(LEN_CAP)
                                                                       : code_length;
                    end
                    CMD_ENCODE:
                        pack_symbol(symbol);
                    CMD_FLUSH:
                    begin
                        want = '{{1'b0, spill_bits}, {1'b0, spill_count}, 1'b1, 1'b1};
                        due_words   = {due_words, want};
                        spill_bits  = '0;
                        spill_count = '0;
                    end
                    default:
                        ;
                endcase
            end
        end
        words_due = due_words.size();
    end

endmodule

// ===== bench/tb_huffman_code_bit_packer_core.sv =====
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer_core;
    import hcbp_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    logic [1:0]        command;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    logic              result_valid;
    logic              result_ready;
    logic [7:0]        out_byte;
    logic [3:0]        valid_bits;
    logic              stream_end;
    logic              last;

    int               fail_count;
    int               words_due;
    int               send_gap_pct = 0;
    int               stall_pct = 0;
    logic             written [256];
    logic [SYM_W-1:0] loaded_syms [$];

    huffman_code_bit_packer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .symbol       (symbol),
        .code_word    (code_word),
        .code_length  (code_length),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .valid_bits   (valid_bits),
        .stream_end   (stream_end),
        .last         (last)
    );

    huffman_code_bit_packer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .symbol       (symbol),
        .code_word    (code_word),
        .code_length  (code_length),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .valid_bits   (valid_bits),
        .stream_end   (stream_end),
        .last         (last),
        .fail_count   (fail_count),
        .words_due    (words_due)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_word(input logic [1:0] cmd, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] cw, input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        command     <= cmd;
        symbol      <= sym;
        code_word   <= cw;
        code_length <= len;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (cmd == CMD_LOAD && !written[sym])
        begin
            written[sym] = 1'b1;
            loaded_syms  = {loaded_syms, sym};
        end
    endtask

    // hold the sender until every word owed has come out
    task automatic drain_words();
        item_valid <= 1'b0;
        @(negedge clk);
        while (words_due != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic random_phase(input int gap, input int stall, input int count);
        int               sent;
        int               r;
        int               pick;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        send_gap_pct = gap;
        stall_pct    = stall;
        sent         = 0;
        while (sent < count)
        begin
            r = $urandom_range(99);
            if (r < 20 || loaded_syms.size() == 0)
            begin
                sym  = ($urandom_range(1) != 0) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
                pick = $urandom_range(9);
                if (pick < 7)
                    len = 6'($urandom_range(12));
                else if (pick < 9)
                    len = 6'($urandom_range(63));
                else
                    len = 6'd32;
                send_word(CMD_LOAD, sym, $urandom, len);
                sent++;
            end
            else if (r < 85)
            begin
                sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
                send_word(CMD_ENCODE, sym, $urandom, 6'($urandom_range(63)));
                sent++;
            end
            else if (r < 95)
            begin
                send_word(CMD_FLUSH, 8'($urandom_range(255)), $urandom, 6'($urandom_range(63)));
                sent++;
            end
            else
                send_word(CMD_UNUSED, 8'($urandom_range(255)), $urandom,
                          6'($urandom_range(63)));
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        command      <= CMD_LOAD;
        symbol       <= '0;
        code_word    <= '0;
        code_length  <= '0;
        result_ready <= 1'b0;
        for (int i = 0; i < 256; i++)
            written[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
        send_word(CMD_ENCODE, 8'd200, 32'hFFFF_FFFF, 6'd63);
        send_word(CMD_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
        send_word(CMD_LOAD, 8'd255, 32'd0, 6'd0);
        send_word(CMD_LOAD, 8'd1, 32'hA5A5_5A5A, 6'd63);
        send_word(CMD_LOAD, 8'd2, 32'h0000_0005, 6'd3);
        send_word(CMD_LOAD, 8'd3, 32'h0000_0001, 6'd1);
        send_word(CMD_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'd63);
        send_word(CMD_ENCODE, 8'd2, 32'd0, 6'd0);
        send_word(CMD_ENCODE, 8'd0, 32'd0, 6'd0);
        send_word(CMD_ENCODE, 8'd1, 32'd0, 6'd0);
        send_word(CMD_ENCODE, 8'd3, 32'd0, 6'd0);
        send_word(CMD_FLUSH, 8'd255, 32'hFFFF_FFFF, 6'd63);
        send_word(CMD_LOAD, 8'd4, 32'hDEAD_BEEF, 6'd7);
        send_word(CMD_ENCODE, 8'd4, 32'd0, 6'd0);
        send_word(CMD_ENCODE, 8'd4, 32'd0, 6'd0);
        send_word(CMD_LOAD, 8'd5, 32'h1234_5678, 6'd33);
        send_word(CMD_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63);
        send_word(CMD_ENCODE, 8'd5, 32'd0, 6'd0);
        send_word(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
        send_word(CMD_LOAD, 8'd6, 32'h0000_003C, 6'd8);
        send_word(CMD_ENCODE, 8'd6, 32'd0, 6'd0);
        send_word(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
        drain_words();

        random_phase(0, 0, 35);
        drain_words();
        random_phase(51, 0, 35);
        random_phase(0, 51, 35);
        drain_words();
        random_phase(37, 37, 35);
        drain_words();

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/hcbp_pkg.sv
hdl/hcbp_table.sv
hdl/hcbp_packer.sv
hdl/huffman_code_bit_packer_core.sv
bench/huffman_code_bit_packer_checker.sv
bench/tb_huffman_code_bit_packer_core.sv
